@@ design/csv_quoted_field_parser_core_assert.svh @@
// Assertion macros used by the checker module.
`ifndef CSV_QUOTED_FIELD_PARSER_CORE_ASSERT_SVH
`define CSV_QUOTED_FIELD_PARSER_CORE_ASSERT_SVH

// Clocked check, off while reset is high.
`define CSVQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CSVQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/csvq_pkg.sv @@
`timescale 1ns / 1ps
package csvq_pkg;

  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;

  // register indexes (paddr[2])
  localparam logic REG_QUOTE     = 1'b0;
  localparam logic REG_SEPARATOR = 1'b1;

  typedef enum logic [1:0] {
    MODE_OUT   = 2'd0,  // outside any field
    MODE_IN    = 2'd1,  // inside a quoted field
    MODE_QPEND = 2'd2,  // inside, quote seen, next byte decides
    MODE_SPEND = 2'd3   // outside, separator seen
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_LINE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic       dropped;
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // All results caused by one byte; slot 0 goes out first.
  typedef struct packed {
    result_t [2:0] slot;
    logic    [1:0] cnt;
  } group_t;

endpackage

@@ design/csvq_decode.sv @@
`timescale 1ns / 1ps
module csvq_decode (
  input  csvq_pkg::mode_t  mode,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic [7:0]       quote_byte,
  input  logic [7:0]       separator_byte,
  output csvq_pkg::mode_t  mode_next,
  output csvq_pkg::group_t grp
);
  import csvq_pkg::*;

  logic          q_hit;
  logic          s_hit;
  mode_t         os_mode;   // mode after handling the byte as outside a field
  logic          os_empty;  // outside handling emits an empty field
  mode_t         mode_body; // mode before the line-end override
  result_t [2:0] slots;
  logic    [1:0] n;

  assign q_hit    = (in_byte == quote_byte);
  assign s_hit    = (in_byte == separator_byte);
  assign os_empty = !q_hit && s_hit && in_last;

  always_comb begin
    if (q_hit) begin
      os_mode = MODE_IN;
    end else if (s_hit && !in_last) begin
      os_mode = MODE_SPEND;
    end else begin
      os_mode = MODE_OUT;
    end
  end

  always_comb begin
    case (mode)
      MODE_OUT:   mode_body = os_mode;
      MODE_IN:    mode_body = q_hit ? (in_last ? MODE_OUT : MODE_QPEND) : MODE_IN;
      MODE_QPEND: mode_body = q_hit ? MODE_IN : os_mode;
      MODE_SPEND: mode_body = os_mode;
      default:    mode_body = MODE_OUT;
    endcase
  end

  assign mode_next = in_last ? MODE_OUT : mode_body;

  always_comb begin
    slots = '0;
    n     = 2'd0;
    case (mode)
      MODE_OUT: begin
        if (os_empty) begin
          slots[n] = '{dropped: 1'b0, data: 8'h00, kind: KIND_EMPTY};
          n = n + 2'd1;
        end
      end
      MODE_IN: begin
        if (q_hit) begin
          if (in_last) begin
            slots[n] = '{dropped: 1'b0, data: 8'h00, kind: KIND_END};
            n = n + 2'd1;
          end
        end else begin
          slots[n] = '{dropped: 1'b0, data: in_byte, kind: KIND_BYTE};
          n = n + 2'd1;
        end
      end
      MODE_QPEND: begin
        if (q_hit) begin
          // doubled quote
          slots[n] = '{dropped: 1'b0, data: in_byte, kind: KIND_BYTE};
          n = n + 2'd1;
        end else begin
          slots[n] = '{dropped: 1'b0, data: 8'h00, kind: KIND_END};
          n = n + 2'd1;
          if (os_empty) begin
            slots[n] = '{dropped: 1'b0, data: 8'h00, kind: KIND_EMPTY};
            n = n + 2'd1;
          end
        end
      end
      MODE_SPEND: begin
        if (s_hit) begin
          slots[n] = '{dropped: 1'b0, data: 8'h00, kind: KIND_EMPTY};
          n = n + 2'd1;
        end
        if (os_empty) begin
          slots[n] = '{dropped: 1'b0, data: 8'h00, kind: KIND_EMPTY};
          n = n + 2'd1;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
    if (in_last) begin
      slots[n] = '{dropped: (mode_body == MODE_IN), data: 8'h00, kind: KIND_LINE};
      n = n + 2'd1;
    end
  end

  assign grp.slot = slots;
  assign grp.cnt  = n;

endmodule

@@ design/csvq_emit.sv @@
`timescale 1ns / 1ps
module csvq_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             grp_valid,
  input  csvq_pkg::group_t grp,
  output logic             grp_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);
  import csvq_pkg::*;

  result_t [2:0] slot;
  logic    [1:0] cnt;
  logic          take;
  logic          load;

  assign take      = m_tvalid && m_tready;
  assign grp_ready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign load      = grp_valid && grp_ready && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp.slot;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = slot[0].data;
  assign m_tuser  = {slot[0].dropped, slot[0].kind};
  assign m_tlast  = (cnt == 2'd1);

endmodule

@@ design/csv_quoted_field_parser_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Handshake
// s_*       in   tdata = in_byte, tlast = last_in_line    tvalid/tready
// m_*       out  tdata = out_byte, tuser = {dropped,kind}, tvalid/tready
//                tlast = last_of_run
// APB       in   quote_byte @0x0, separator_byte @0x4     psel/penable, pready=1
//
// One byte is accepted per cycle unless the output stalls; the input register
// holds it while the mode update and its results (zero to three) are formed.
// A byte's results hold the output stage until all have gone out: the result
// buffer drains one result per cycle while m_tready is high, so the sustained
// rate is one byte per cycle when each byte makes at most one result.
// Reset (rst, synchronous) empties both stages, returns the mode to outside
// any field and loads the default quote and separator bytes.
// m_tready low stalls the result buffer, then the input register, then s_tready.
module csv_quoted_field_parser_core (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [2:0]  m_tuser,   // [1:0] kind, [2] dropped_partial
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csvq_pkg::*;

  logic [7:0] quote_byte;
  logic [7:0] separator_byte;
  logic       cfg_wr;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_take;

  mode_t      mode;
  mode_t      mode_next;
  group_t     grp;
  logic       grp_ready;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_byte     <= QUOTE_RESET;
      separator_byte <= SEPARATOR_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_QUOTE:     quote_byte     <= pwdata[7:0];
        REG_SEPARATOR: separator_byte <= pwdata[7:0];
        default:       quote_byte     <= quote_byte;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_QUOTE:     prdata = {24'h0, quote_byte};
      REG_SEPARATOR: prdata = {24'h0, separator_byte};
      default:       prdata = 32'h0;
    endcase
  end

  // ---------------- input stage ----------------
  // A byte with no results leaves at once; otherwise it waits for room
  // in the result buffer.
  assign in_take  = in_valid && ((grp.cnt == 2'd0) || grp_ready);
  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // mode only moves when the byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OUT;
    end else if (in_take) begin
      mode <= mode_next;
    end
  end

  csvq_decode u_decode (
    .mode           (mode),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .quote_byte     (quote_byte),
    .separator_byte (separator_byte),
    .mode_next      (mode_next),
    .grp            (grp)
  );

  // ---------------- result buffer ----------------
  csvq_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (in_valid),
    .grp       (grp),
    .grp_ready (grp_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ design/csvq_checker.sv @@
`timescale 1ns / 1ps
`include "csv_quoted_field_parser_core_assert.svh"
module csvq_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);
  import csvq_pkg::*;

  `CSVQ_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_tvalid, "output valid right after reset")
  `CSVQ_ASSERT(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transfer changed")
  `CSVQ_ASSERT(a_byte_zero, m_tvalid && (m_tuser[1:0] != KIND_BYTE) |-> (m_tdata == 8'h00), "nonzero byte on a non-byte result")
  `CSVQ_ASSERT(a_drop_on_line, m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == KIND_LINE), "dropped flag off a line end")
  `CSVQ_ASSERT(a_line_last, m_tvalid && (m_tuser[1:0] == KIND_LINE) |-> m_tlast, "line end not last of its run")

endmodule

bind csv_quoted_field_parser_core csvq_checker u_csvq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ verif/csv_quoted_field_parser_core_tb.sv @@
`timescale 1ns / 1ps
module csv_quoted_field_parser_core_tb;
  import csvq_pkg::*;

  // One expected output transfer.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       drop;     // dropped_partial
    logic       run_end;  // last_of_run
  } res_t;

  // One directed stimulus row; typed rows carry their own results.
  typedef struct packed {
    logic [7:0]    b;
    logic          lst;
    logic          typed;
    logic [1:0]    n;
    res_t [2:0]    r;
  } row_t;

  localparam res_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] out_byte
  logic [2:0]  m_tuser;           // [1:0] kind, [2] dropped_partial
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  csv_quoted_field_parser_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state: mirrors the parser mode and both registers.
  mode_t      scan_mode = MODE_OUT;
  logic [7:0] quote_cfg = QUOTE_RESET;
  logic [7:0] sep_cfg   = SEPARATOR_RESET;

  res_t field_events_due[$];  // results still owed by the block, oldest first
  res_t head;
  row_t dir_rows[$];
  int   fails = 0;
  int   sent = 0;
  bit   calm = 1'b0;          // no idling on either side
  bit   hold_req = 1'b0;      // asks the sink for one long hold-off

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic res_t rs(input kind_t k, input logic [7:0] d, input logic p);
    return '{kind: k, data: d, drop: p, run_end: 1'b0};
  endfunction

  function automatic void add_result(inout int n, inout res_t [2:0] r, input kind_t k,
                                     input logic [7:0] d, input logic p);
    if (n < 3) begin
      r[n] = rs(k, d, p);
      n++;
    end
  endfunction

  // Byte seen outside any field: quote opens, separator may go pending.
  function automatic void take_outside(input logic [7:0] b, input logic lst,
                                       inout int n, inout res_t [2:0] r);
    if (b == quote_cfg) begin
      scan_mode = MODE_IN;
    end else if (b == sep_cfg) begin
      if (lst) begin
        add_result(n, r, KIND_EMPTY, 8'h00, 1'b0);
        scan_mode = MODE_OUT;
      end else begin
        scan_mode = MODE_SPEND;
      end
    end else begin
      scan_mode = MODE_OUT;
    end
  endfunction

  // Advances the mode by one byte and returns the results it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic lst,
                                     output int n, output res_t [2:0] r);
    n = 0;
    r = '0;
    case (scan_mode)
      MODE_OUT: begin
        take_outside(b, lst, n, r);
      end
      MODE_IN: begin
        if (b != quote_cfg) begin
          add_result(n, r, KIND_BYTE, b, 1'b0);
        end else if (lst) begin
          add_result(n, r, KIND_END, 8'h00, 1'b0);
          scan_mode = MODE_OUT;
        end else begin
          scan_mode = MODE_QPEND;
        end
      end
      MODE_QPEND: begin
        if (b == quote_cfg) begin
          add_result(n, r, KIND_BYTE, b, 1'b0);
          scan_mode = MODE_IN;
        end else begin
          add_result(n, r, KIND_END, 8'h00, 1'b0);
          scan_mode = MODE_OUT;
          take_outside(b, lst, n, r);
        end
      end
      default: begin
        // separator pending: a second separator makes an empty field first
        scan_mode = MODE_OUT;
        if (b == sep_cfg) add_result(n, r, KIND_EMPTY, 8'h00, 1'b0);
        take_outside(b, lst, n, r);
      end
    endcase
    if (lst) begin
      add_result(n, r, KIND_LINE, 8'h00, scan_mode == MODE_IN);
      scan_mode = MODE_OUT;
    end
    if (n > 0) r[n - 1].run_end = 1'b1;
  endfunction

  function automatic row_t mk_row(input logic [7:0] b, input logic lst, input logic typed,
                                  input logic [1:0] n, input res_t r0, input res_t r1,
                                  input res_t r2);
    return '{b: b, lst: lst, typed: typed, n: n, r: {r2, r1, r0}};
  endfunction

  // Offers one byte, waits for its transfer, then books the expected results.
  // Typed rows still run the predictor so that its mode stays in step.
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input logic [1:0] tn, input res_t [2:0] tr);
    int n;
    res_t [2:0] r;
    if (!calm && !hold_req && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    parse_byte(b, lst, n, r);
    if (typed) begin
      n = int'(tn);
      r = tr;
      if (n > 0) r[n - 1].run_end = 1'b1;
    end
    for (int i = 0; i < n; i++) field_events_due.push_back(r[i]);
    sent++;
  endtask

  // One line: mostly well-formed quoted/bare/empty fields, some noise.
  task automatic send_line();
    logic [7:0] bytes[$];
    int nf;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: bytes.push_back(quote_cfg);
          1: bytes.push_back(sep_cfg);
          default: bytes.push_back(rand_byte());
        endcase
      end
    end else begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) bytes.push_back(sep_cfg);
        case ($urandom_range(0, 5))
          0: ;  // empty field
          1: repeat ($urandom_range(1, 3)) bytes.push_back(rand_byte());
          default: begin
            bytes.push_back(quote_cfg);
            repeat ($urandom_range(0, 5)) begin
              if ($urandom_range(0, 4) == 0) begin
                bytes.push_back(quote_cfg);
                bytes.push_back(quote_cfg);
              end else begin
                bytes.push_back(rand_byte());
              end
            end
            if ($urandom_range(0, 7) != 0) bytes.push_back(quote_cfg);  // else left open
          end
        endcase
      end
      if ($urandom_range(0, 5) == 0) bytes.push_back(sep_cfg);  // trailing separator
      if (bytes.size() == 0) bytes.push_back(rand_byte());
    end
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, 1'b0, 2'd0, '0);
  endtask

  // APB read in two phases; prdata is taken at the access edge.
  task automatic check_reg(input logic idx, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      $error("reg %0d readback: expected %02h, got %02h", idx, want, prdata[7:0]);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // APB write; upper data bits are junk the block must ignore.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    logic [31:0] w;
    w = $urandom;
    w[7:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_QUOTE) quote_cfg = val;
    else sep_cfg = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    check_reg(idx, val);
  endtask

  // Drop valid, drain all owed results, then give a last byte with no
  // results time to leave the input register.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (field_events_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (field_events_due.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h", m_tuser[1:0], m_tdata);
        fails++;
      end else begin
        head = field_events_due.pop_front();
        if (m_tuser[1:0] !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, m_tuser[1:0]);
          fails++;
        end
        if (m_tdata !== head.data) begin
          $error("out_byte: expected %02h, got %02h", head.data, m_tdata);
          fails++;
        end
        if (m_tuser[2] !== head.drop) begin
          $error("dropped_partial: expected %0d, got %0d", head.drop, m_tuser[2]);
          fails++;
        end
        if (m_tlast !== head.run_end) begin
          $error("last_of_run: expected %0d, got %0d", head.run_end, m_tlast);
          fails++;
        end
      end
    end
  end

  // Sink: random stall bursts, plus one long hold-off on request so the
  // result buffer fills and the block pushes back on s_tready.
  initial begin : sink
    int held;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        for (held = 0; held < 80; held++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("csv_quoted_field_parser_core_tb failed");
    $finish;
  end

  initial begin : stim
    logic [7:0] set_q[6];
    logic [7:0] set_s[6];
    int goal;

    // Directed rows, default registers ('"' = 22, ',' = 2C).
    dir_rows.push_back(mk_row(8'h22, 0, 1, 0, NO_RES, NO_RES, NO_RES));  // open quote
    dir_rows.push_back(mk_row(8'h61, 0, 1, 1, rs(KIND_BYTE, 8'h61, 0), NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));  // quote pending
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));  // doubled quote
    dir_rows.push_back(mk_row(8'h00, 0, 1, 1, rs(KIND_BYTE, 8'h00, 0), NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'hFF, 0, 1, 1, rs(KIND_BYTE, 8'hFF, 0), NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h2C, 0, 0, 0, NO_RES, NO_RES, NO_RES));  // closes, sep pending
    dir_rows.push_back(mk_row(8'h2C, 0, 0, 0, NO_RES, NO_RES, NO_RES));  // adjacent seps
    dir_rows.push_back(mk_row(8'h78, 0, 0, 0, NO_RES, NO_RES, NO_RES));  // bare byte
    dir_rows.push_back(mk_row(8'h2C, 1, 1, 2, rs(KIND_EMPTY, 8'h00, 0),  // sep as last byte
                              rs(KIND_LINE, 8'h00, 0), NO_RES));
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h22, 1, 1, 2, rs(KIND_END, 8'h00, 0),    // quote last, inside
                              rs(KIND_LINE, 8'h00, 0), NO_RES));
    dir_rows.push_back(mk_row(8'h22, 1, 1, 1, rs(KIND_LINE, 8'h00, 1),   // open quote last
                              NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h62, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h63, 1, 1, 2, rs(KIND_BYTE, 8'h63, 0),   // unterminated field
                              rs(KIND_LINE, 8'h00, 1), NO_RES));
    dir_rows.push_back(mk_row(8'h2C, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));  // opens after sep
    dir_rows.push_back(mk_row(8'h64, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h22, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h7A, 1, 0, 0, NO_RES, NO_RES, NO_RES));  // pending quote, last
    dir_rows.push_back(mk_row(8'h2C, 0, 0, 0, NO_RES, NO_RES, NO_RES));
    dir_rows.push_back(mk_row(8'h2C, 1, 1, 3, rs(KIND_EMPTY, 8'h00, 0),  // three results
                              rs(KIND_EMPTY, 8'h00, 0), rs(KIND_LINE, 8'h00, 0)));
    dir_rows.push_back(mk_row(8'hFF, 1, 1, 1, rs(KIND_LINE, 8'h00, 0), NO_RES, NO_RES));

    // Random phases: odd registers, both extremes, quote equal to separator,
    // a random pair, then back to the defaults.
    set_q = '{8'h27, 8'h00, 8'hFF, 8'h41, rand_byte(), QUOTE_RESET};
    set_s = '{8'h3B, 8'hFF, 8'h00, 8'h41, rand_byte(), SEPARATOR_RESET};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    check_reg(REG_QUOTE, QUOTE_RESET);
    check_reg(REG_SEPARATOR, SEPARATOR_RESET);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].n,
                dir_rows[i].r);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(REG_QUOTE, set_q[ph]);
      write_reg(REG_SEPARATOR, set_s[ph]);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) calm = 1'b1;
      goal = sent + 62;
      while (sent < goal) send_line();
      // leave a pending mode open so the next registers resolve it mid-line
      if (ph < 5) begin
        if (ph % 2 == 1) begin
          send_byte(quote_cfg, 1'b0, 1'b0, 2'd0, '0);
          send_byte(rand_byte(), 1'b0, 1'b0, 2'd0, '0);
          send_byte(quote_cfg, 1'b0, 1'b0, 2'd0, '0);
        end else begin
          send_byte(sep_cfg, 1'b0, 1'b0, 2'd0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    for (int k = 0; k < 5000 && field_events_due.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (field_events_due.size() != 0) begin
      $error("%0d expected results never arrived", field_events_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("csv_quoted_field_parser_core_tb passed");
    end else begin
      $display("csv_quoted_field_parser_core_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/csvq_pkg.sv
design/csvq_decode.sv
design/csvq_emit.sv
design/csv_quoted_field_parser_core.sv
design/csvq_checker.sv
verif/csv_quoted_field_parser_core_tb.sv
